// File: rtl/core/rvm_pkg.sv
package rvm_pkg;

   // Default sizes of the sample store, phase accumulator and gain format.
   localparam int STORE_DEPTH_DEF = 16384;
   localparam int PHASE_BITS_DEF  = 20;
   localparam int GAIN_SHIFT_DEF  = 16;

   // Widest phase and store address that the parameter ranges allow.
   localparam int PHASE_MAX_W = 24;
   localparam int ADDR_MAX_W  = 21;

   // Depth of the word queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Register reset values.
   localparam logic [13:0] SPEED_WHOLE_RST   = 14'd1;
   localparam logic [19:0] SPEED_PART_RST    = 20'd0;
   localparam logic [14:0] GAIN_RST          = 15'd16384;
   localparam logic        STEREO_SOURCE_RST = 1'b1;
   localparam logic        EIGHT_BIT_RST     = 1'b0;
   localparam logic        LOOPING_RST       = 1'b0;
   localparam logic [14:0] FRAME_COUNT_RST   = 15'd16384;

   // Input word commands.
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_MIX   = 2'd1,
      CMD_SEEK  = 2'd2
   } cmd_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_SPEED_WHOLE   = 3'd0,
      REG_SPEED_PART    = 3'd1,
      REG_RIGHT_GAIN    = 3'd2,
      REG_LEFT_GAIN     = 3'd3,
      REG_STEREO_SOURCE = 3'd4,
      REG_EIGHT_BIT     = 3'd5,
      REG_LOOPING       = 3'd6,
      REG_FRAME_COUNT   = 3'd7
   } reg_idx_type;

   // All configuration registers as one group.
   typedef struct packed {
      logic [13:0] speed_whole;
      logic [19:0] speed_part;
      logic [14:0] right_gain;
      logic [14:0] left_gain;
      logic        stereo_source;
      logic        eight_bit;
      logic        looping;
      logic [14:0] frame_count;
   } cfg_type;

   // One mix word on its way from the front part to the back part.
   typedef struct packed {
      logic               ended;
      logic signed [15:0] in_left;
      logic signed [15:0] in_right;
      logic signed [15:0] smp_left;
      logic signed [15:0] smp_right;
   } mix_item_type;

   // Turns a raw store word into a signed 16-bit sample. An unsigned byte
   // minus 128, moved up by 8 bits, is the byte with its top bit flipped.
   function automatic logic signed [15:0] to_pcm(input logic [15:0] word,
                                                  input logic eight_bit);
      logic signed [15:0] pcm;
      if (eight_bit) begin
         pcm = {~word[7], word[6:0], 8'd0};
      end else begin
         pcm = word;
      end
      return pcm;
   endfunction

endpackage

// File: rtl/core/resampling_voice_mixer.sv
// Resampling voice mixer. One sampled voice is played from an internal sample
// store and mixed into a stereo stream. A CMD_WRITE word loads one store entry,
// CMD_SEEK sets the play position, and each CMD_MIX word carries one stereo
// frame in and returns one frame out: the source sample scaled by the clipped
// gain and added with 16-bit saturation, or the frame unchanged with ended set
// once the voice has run past frame_count. Words are taken at one per cycle
// unless req_stall holds them: the play position is updated by a fractional
// add with carry and one wrap compare, and the store has two read ports so a
// stereo frame reads both of its entries at once. A four-entry queue between
// the store read and the multiply-and-saturate pipeline lets the input keep
// flowing for a few words while the output is held. The store has no reset
// and needs no clearing: an entry must be written before it is played.
// Configuration registers sit on an APB-style port; they are to be written
// while idle by the user, and the block itself does not enforce it.
module resampling_voice_mixer #(
   parameter int STORE_DEPTH = rvm_pkg::STORE_DEPTH_DEF,
   parameter int PHASE_BITS  = rvm_pkg::PHASE_BITS_DEF,
   parameter int GAIN_SHIFT  = rvm_pkg::GAIN_SHIFT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Input words.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [13:0]        req_store_addr,
   input  logic [15:0]        req_store_word,
   input  logic signed [15:0] req_mix_in_left,
   input  logic signed [15:0] req_mix_in_right,
   input  logic [13:0]        req_start_frame,
   input  logic [19:0]        req_start_phase,
   // Result words.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_mix_out_left,
   output logic signed [15:0] rsp_mix_out_right,
   output logic               rsp_ended,
   // Configuration port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   rvm_pkg::cfg_type      cfg_ff, cfg_in;
   rvm_pkg::reg_idx_type  reg_idx;
   logic                  cfg_we;
   logic                  q_full, q_push, q_pop, q_not_empty;
   rvm_pkg::mix_item_type q_push_item, q_head_item;

   // Register file write.
   assign pready  = 1'b1;
   assign reg_idx = rvm_pkg::reg_idx_type'(paddr[4:2]);
   assign cfg_we  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         case (reg_idx)
            rvm_pkg::REG_SPEED_WHOLE:   cfg_in.speed_whole   = pwdata[13:0];
            rvm_pkg::REG_SPEED_PART:    cfg_in.speed_part    = pwdata[19:0];
            rvm_pkg::REG_RIGHT_GAIN:    cfg_in.right_gain    = pwdata[14:0];
            rvm_pkg::REG_LEFT_GAIN:     cfg_in.left_gain     = pwdata[14:0];
            rvm_pkg::REG_STEREO_SOURCE: cfg_in.stereo_source = pwdata[0];
            rvm_pkg::REG_EIGHT_BIT:     cfg_in.eight_bit     = pwdata[0];
            rvm_pkg::REG_LOOPING:       cfg_in.looping       = pwdata[0];
            rvm_pkg::REG_FRAME_COUNT:   cfg_in.frame_count   = pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_whole   <= rvm_pkg::SPEED_WHOLE_RST;
         cfg_ff.speed_part    <= rvm_pkg::SPEED_PART_RST;
         cfg_ff.right_gain    <= rvm_pkg::GAIN_RST;
         cfg_ff.left_gain     <= rvm_pkg::GAIN_RST;
         cfg_ff.stereo_source <= rvm_pkg::STEREO_SOURCE_RST;
         cfg_ff.eight_bit     <= rvm_pkg::EIGHT_BIT_RST;
         cfg_ff.looping       <= rvm_pkg::LOOPING_RST;
         cfg_ff.frame_count   <= rvm_pkg::FRAME_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register file read.
   always_comb begin
      case (reg_idx)
         rvm_pkg::REG_SPEED_WHOLE:   prdata = {18'd0, cfg_ff.speed_whole};
         rvm_pkg::REG_SPEED_PART:    prdata = {12'd0, cfg_ff.speed_part};
         rvm_pkg::REG_RIGHT_GAIN:    prdata = {17'd0, cfg_ff.right_gain};
         rvm_pkg::REG_LEFT_GAIN:     prdata = {17'd0, cfg_ff.left_gain};
         rvm_pkg::REG_STEREO_SOURCE: prdata = {31'd0, cfg_ff.stereo_source};
         rvm_pkg::REG_EIGHT_BIT:     prdata = {31'd0, cfg_ff.eight_bit};
         rvm_pkg::REG_LOOPING:       prdata = {31'd0, cfg_ff.looping};
         rvm_pkg::REG_FRAME_COUNT:   prdata = {17'd0, cfg_ff.frame_count};
         default:                    prdata = '0;
      endcase
   end

   // Front part: position, sample store, classification.
   rvm_front #(
      .STORE_DEPTH (STORE_DEPTH),
      .PHASE_BITS  (PHASE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_store_addr   (req_store_addr),
      .req_store_word   (req_store_word),
      .req_mix_in_left  (req_mix_in_left),
      .req_mix_in_right (req_mix_in_right),
      .req_start_frame  (req_start_frame),
      .req_start_phase  (req_start_phase),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   // Queue between the two parts.
   rvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (q_head_item)
   );

   // Back part: gain, mix and saturation.
   rvm_back #(
      .GAIN_SHIFT (GAIN_SHIFT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_not_empty       (q_not_empty),
      .q_item            (q_head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mix_out_left  (rsp_mix_out_left),
      .rsp_mix_out_right (rsp_mix_out_right),
      .rsp_ended         (rsp_ended)
   );

endmodule

// File: rtl/core/rvm_front.sv
module rvm_front #(
   parameter int STORE_DEPTH = rvm_pkg::STORE_DEPTH_DEF,
   parameter int PHASE_BITS  = rvm_pkg::PHASE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [13:0]            req_store_addr,
   input  logic [15:0]            req_store_word,
   input  logic signed [15:0]     req_mix_in_left,
   input  logic signed [15:0]     req_mix_in_right,
   input  logic [13:0]            req_start_frame,
   input  logic [19:0]            req_start_phase,
   input  rvm_pkg::cfg_type       cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output rvm_pkg::mix_item_type  q_item
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Play position.
   logic [15:0]            frame_ff, frame_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;

   // Sample store and its registered read data.
   logic [15:0]            store_ff [STORE_DEPTH];
   logic [15:0]            rd_a_ff, rd_b_ff;

   // Word waiting for the store read data.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_ended_ff;
   logic signed [15:0]     s1_in_l_ff, s1_in_r_ff;

   logic                   accept;
   logic                   is_mix, is_write, is_seek;
   logic [15:0]            count16;
   logic [15:0]            frame_wrap;
   logic                   active;
   logic [rvm_pkg::PHASE_MAX_W-1:0] part_wide, start_wide;
   logic [PHASE_BITS-1:0]  part_m, start_m;
   logic [PHASE_BITS:0]    phase_sum;
   logic [15:0]            frame_adv, frame_adv_wrap;
   logic [rvm_pkg::ADDR_MAX_W-1:0] waddr_wide, ra_stereo, rb_wide, ra_mono;
   logic [ADDR_W-1:0]      waddr, raddr_a, raddr_b;
   logic                   store_we, rd_en;

   // Handshake and command decode.
   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = s1_valid_ff && !q_full;

   always_comb begin
      is_write = 1'b0;
      is_mix   = 1'b0;
      is_seek  = 1'b0;
      case (rvm_pkg::cmd_type'(req_cmd))
         rvm_pkg::CMD_WRITE: is_write = 1'b1;
         rvm_pkg::CMD_MIX:   is_mix   = 1'b1;
         rvm_pkg::CMD_SEEK:  is_seek  = 1'b1;
         default: ;
      endcase
   end

   // Wrap at the start of a mix and decide whether the voice still plays.
   assign count16    = {1'b0, cfg.frame_count};
   assign frame_wrap = (cfg.looping && frame_ff >= count16) ? frame_ff - count16 : frame_ff;
   assign active     = frame_wrap < count16;

   // Step the position: fractional add, its carry into the whole part, one wrap.
   assign part_wide      = {{(rvm_pkg::PHASE_MAX_W - 20){1'b0}}, cfg.speed_part};
   assign start_wide     = {{(rvm_pkg::PHASE_MAX_W - 20){1'b0}}, req_start_phase};
   assign part_m         = part_wide[PHASE_BITS-1:0];
   assign start_m        = start_wide[PHASE_BITS-1:0];
   assign phase_sum      = {1'b0, phase_ff} + {1'b0, part_m};
   assign frame_adv      = frame_wrap + {2'd0, cfg.speed_whole} + {15'd0, phase_sum[PHASE_BITS]};
   assign frame_adv_wrap = (cfg.looping && frame_adv >= count16) ? frame_adv - count16
                                                                  : frame_adv;

   always_comb begin
      frame_in = frame_ff;
      phase_in = phase_ff;
      if (accept && is_seek) begin
         frame_in = {2'd0, req_start_frame};
         phase_in = start_m;
      end else if (accept && is_mix) begin
         if (active) begin
            frame_in = frame_adv_wrap;
            phase_in = phase_sum[PHASE_BITS-1:0];
         end else begin
            frame_in = frame_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         phase_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         phase_ff <= phase_in;
      end
   end

   // Store addresses. A stereo frame p is the right word at 2p and the left at 2p+1.
   assign waddr_wide = {{(rvm_pkg::ADDR_MAX_W - 14){1'b0}}, req_store_addr};
   assign ra_stereo  = {{(rvm_pkg::ADDR_MAX_W - 17){1'b0}}, frame_wrap, 1'b0};
   assign rb_wide    = {{(rvm_pkg::ADDR_MAX_W - 17){1'b0}}, frame_wrap, 1'b1};
   assign ra_mono    = {{(rvm_pkg::ADDR_MAX_W - 16){1'b0}}, frame_wrap};
   assign waddr      = waddr_wide[ADDR_W-1:0];
   assign raddr_a    = cfg.stereo_source ? ra_stereo[ADDR_W-1:0] : ra_mono[ADDR_W-1:0];
   assign raddr_b    = rb_wide[ADDR_W-1:0];
   assign store_we   = accept && is_write;
   assign rd_en      = accept && is_mix && active;

   // Sample store: one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[waddr] <= req_store_word;
      end
      if (rd_en) begin
         rd_a_ff <= store_ff[raddr_a];
         rd_b_ff <= store_ff[raddr_b];
      end
   end

   // Mix word held until the queue takes it.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && is_mix) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_mix) begin
         s1_ended_ff <= !active;
         s1_in_l_ff  <= req_mix_in_left;
         s1_in_r_ff  <= req_mix_in_right;
      end
   end

   // Queue entry with the source samples already in signed form.
   always_comb begin
      q_item.ended     = s1_ended_ff;
      q_item.in_left   = s1_in_l_ff;
      q_item.in_right  = s1_in_r_ff;
      q_item.smp_right = rvm_pkg::to_pcm(rd_a_ff, cfg.eight_bit);
      q_item.smp_left  = rvm_pkg::to_pcm(cfg.stereo_source ? rd_b_ff : rd_a_ff,
                                         cfg.eight_bit);
   end

endmodule

// File: rtl/core/rvm_queue.sv
module rvm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rvm_pkg::mix_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output rvm_pkg::mix_item_type head_item
);

   rvm_pkg::mix_item_type         slot_ff [rvm_pkg::QUEUE_DEPTH];
   logic [rvm_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rvm_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rvm_pkg::QUEUE_PTR_W:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   // Status from the registered fill count.
   assign full      = count_ff == (rvm_pkg::QUEUE_PTR_W + 1)'(rvm_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and count update; a push and a pop may share a cycle.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/rvm_back.sv
module rvm_back #(
   parameter int GAIN_SHIFT = rvm_pkg::GAIN_SHIFT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rvm_pkg::cfg_type      cfg,
   input  logic                  q_not_empty,
   input  rvm_pkg::mix_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_mix_out_left,
   output logic signed [15:0]    rsp_mix_out_right,
   output logic                  rsp_ended
);

   localparam logic [19:0] GAIN_MAX = 20'd1 << (GAIN_SHIFT - 2);

   // Gains clipped at one quarter.
   logic [14:0]        gain_l_ff, gain_r_ff;
   // Multiply stage.
   logic               a_valid_ff;
   logic               a_ended_ff;
   logic signed [15:0] a_in_l_ff, a_in_r_ff;
   logic signed [31:0] a_prod_l_ff, a_prod_r_ff;
   // Output register.
   logic               out_valid_ff;
   logic               out_ended_ff;
   logic signed [15:0] out_l_ff, out_r_ff, out_l_in, out_r_in;

   logic               advance;
   logic signed [31:0] shift_l, shift_r;
   logic signed [16:0] sum_l, sum_r;

   // Clip the gains once per cycle so the multiply sees a plain register.
   always_ff @(posedge clock) begin
      gain_l_ff <= ({5'd0, cfg.left_gain} > GAIN_MAX) ? GAIN_MAX[14:0] : cfg.left_gain;
      gain_r_ff <= ({5'd0, cfg.right_gain} > GAIN_MAX) ? GAIN_MAX[14:0] : cfg.right_gain;
   end

   // The pipeline moves unless a finished word is held by the consumer.
   assign advance = !(out_valid_ff && rsp_stall);
   assign q_pop   = q_not_empty && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= q_not_empty;
         out_valid_ff <= a_valid_ff;
      end
   end

   // Scale both sides.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ended_ff  <= q_item.ended;
         a_in_l_ff   <= q_item.in_left;
         a_in_r_ff   <= q_item.in_right;
         a_prod_l_ff <= $signed({1'b0, gain_l_ff}) * q_item.smp_left;
         a_prod_r_ff <= $signed({1'b0, gain_r_ff}) * q_item.smp_right;
      end
   end

   // Floor shift of the product, add to the stream and saturate; ended words pass unchanged.
   assign shift_l = a_prod_l_ff >>> GAIN_SHIFT;
   assign shift_r = a_prod_r_ff >>> GAIN_SHIFT;
   assign sum_l   = {a_in_l_ff[15], a_in_l_ff} + shift_l[16:0];
   assign sum_r   = {a_in_r_ff[15], a_in_r_ff} + shift_r[16:0];

   always_comb begin
      if (a_ended_ff) begin
         out_l_in = a_in_l_ff;
         out_r_in = a_in_r_ff;
      end else begin
         out_l_in = (sum_l[16] == sum_l[15]) ? sum_l[15:0] : {sum_l[16], {15{~sum_l[16]}}};
         out_r_in = (sum_r[16] == sum_r[15]) ? sum_r[15:0] : {sum_r[16], {15{~sum_r[16]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ended_ff <= a_ended_ff;
         out_l_ff     <= out_l_in;
         out_r_ff     <= out_r_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ended         = out_ended_ff;
   assign rsp_mix_out_left  = out_l_ff;
   assign rsp_mix_out_right = out_r_ff;

endmodule

// File: rtl/core/rvm_checker.sv
module rvm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_mix_out_left,
   input logic signed [15:0] rsp_mix_out_right,
   input logic               rsp_ended,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [4:0]         paddr,
   input logic [31:0]        pwdata,
   input logic [31:0]        prdata,
   input logic               pready
);

   logic [4:0] loop_addr;
   assign loop_addr = {rvm_pkg::REG_LOOPING, 2'b00};

   // Reset empties the result side.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A held result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mix_out_left)
         && $stable(rsp_mix_out_right) && $stable(rsp_ended))
      else $error("held result word changed");

   // A written looping register reads back its low data bit.
   a_flag_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr == loop_addr ##1 paddr == loop_addr
         |-> prdata == {31'd0, $past(pwdata[0])})
      else $error("looping register read back wrong");

   // No register is wider than 20 bits.
   a_prdata_width: assert property (@(posedge clock) disable iff (reset)
      prdata[31:20] == 12'd0)
      else $error("register read returned bits above the widest register");

endmodule

bind resampling_voice_mixer rvm_checker u_checker (.*);

// File: test/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int WORD_TARGET = 1750;
   localparam int CALM_WORDS = 200;
   localparam int STORE_SIZE = rvm_pkg::STORE_DEPTH_DEF;
   localparam longint GAIN_CAP = longint'(1) << (rvm_pkg::GAIN_SHIFT_DEF - 2);

   // One input word, all fields at the port widths.
   typedef struct packed {
      logic [1:0]         cmd;
      logic [13:0]        store_addr;
      logic [15:0]        store_word;
      logic signed [15:0] in_left;
      logic signed [15:0] in_right;
      logic [13:0]        start_frame;
      logic [19:0]        start_phase;
   } voice_word_type;

   // One output frame as the mixer should produce it.
   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               ended;
   } mix_frame_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = rvm_pkg::CMD_WRITE;
   logic [13:0]        req_store_addr = '0;
   logic [15:0]        req_store_word = '0;
   logic signed [15:0] req_mix_in_left = '0;
   logic signed [15:0] req_mix_in_right = '0;
   logic [13:0]        req_start_frame = '0;
   logic [19:0]        req_start_phase = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_mix_out_left;
   logic signed [15:0] rsp_mix_out_right;
   logic               rsp_ended;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // Shadow of the voice: registers, play position and sample store.
   rvm_pkg::cfg_type voice_cfg = '{speed_whole: rvm_pkg::SPEED_WHOLE_RST,
                                   speed_part: rvm_pkg::SPEED_PART_RST,
                                   right_gain: rvm_pkg::GAIN_RST,
                                   left_gain: rvm_pkg::GAIN_RST,
                                   stereo_source: rvm_pkg::STEREO_SOURCE_RST,
                                   eight_bit: rvm_pkg::EIGHT_BIT_RST,
                                   looping: rvm_pkg::LOOPING_RST,
                                   frame_count: rvm_pkg::FRAME_COUNT_RST};
   logic [15:0] play_frame = '0;
   logic [19:0] play_phase = '0;
   logic [15:0] voice_store [STORE_SIZE];
   bit          store_written [STORE_SIZE];

   mix_frame_type pending_frames [$];
   mix_frame_type want;
   int errors = 0;
   int cycles = 0;
   int words_sent = 0;
   bit idling_on = 1'b1;

   resampling_voice_mixer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_store_addr    (req_store_addr),
      .req_store_word    (req_store_word),
      .req_mix_in_left   (req_mix_in_left),
      .req_mix_in_right  (req_mix_in_right),
      .req_start_frame   (req_start_frame),
      .req_start_phase   (req_start_phase),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mix_out_left  (rsp_mix_out_left),
      .rsp_mix_out_right (rsp_mix_out_right),
      .rsp_ended         (rsp_ended),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scaled source sample: gain clipped at a quarter, floor division.
   function automatic longint scaled_sample(logic [14:0] gain, logic [15:0] raw);
      longint g;
      longint d;
      g = (longint'(gain) > GAIN_CAP) ? GAIN_CAP : longint'(gain);
      if (voice_cfg.eight_bit) begin
         d = longint'(raw[7:0]) - 128;
         return (g * d) >>> (rvm_pkg::GAIN_SHIFT_DEF - 8);
      end
      d = longint'($signed(raw));
      return (g * d) >>> rvm_pkg::GAIN_SHIFT_DEF;
   endfunction

   function automatic logic signed [15:0] clamp_pcm(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // A looping voice past its end goes back by one frame count.
   function automatic void wrap_position();
      if (voice_cfg.looping && play_frame >= {1'b0, voice_cfg.frame_count}) begin
         play_frame = play_frame - {1'b0, voice_cfg.frame_count};
      end
   endfunction

   // Applies one accepted word to the shadow voice and queues its frame, if any.
   task automatic advance_voice(voice_word_type w);
      mix_frame_type f;
      logic [15:0] left_raw;
      logic [15:0] right_raw;
      logic [20:0] phase_sum;
      case (w.cmd)
         rvm_pkg::CMD_WRITE: begin
            voice_store[w.store_addr] = w.store_word;
            store_written[w.store_addr] = 1'b1;
         end
         rvm_pkg::CMD_SEEK: begin
            play_frame = {2'b00, w.start_frame};
            play_phase = w.start_phase;
         end
         rvm_pkg::CMD_MIX: begin
            wrap_position();
            if (play_frame < {1'b0, voice_cfg.frame_count}) begin
               if (voice_cfg.stereo_source) begin
                  right_raw = voice_store[{play_frame[12:0], 1'b0}];
                  left_raw = voice_store[{play_frame[12:0], 1'b1}];
               end else begin
                  right_raw = voice_store[play_frame[13:0]];
                  left_raw = right_raw;
               end
               f.left = clamp_pcm(longint'(w.in_left)
                                  + scaled_sample(voice_cfg.left_gain, left_raw));
               f.right = clamp_pcm(longint'(w.in_right)
                                   + scaled_sample(voice_cfg.right_gain, right_raw));
               f.ended = 1'b0;
               phase_sum = {1'b0, play_phase} + {1'b0, voice_cfg.speed_part};
               play_phase = phase_sum[19:0];
               play_frame = play_frame + {2'b00, voice_cfg.speed_whole}
                            + {15'd0, phase_sum[20]};
               wrap_position();
            end else begin
               f.left = w.in_left;
               f.right = w.in_right;
               f.ended = 1'b1;
            end
            pending_frames.push_back(f);
         end
         default: ;
      endcase
   endtask

   // Drives one word, with an occasional idle burst ahead of it.
   task automatic drive_word(voice_word_type w);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_store_addr <= w.store_addr;
      req_store_word <= w.store_word;
      req_mix_in_left <= w.in_left;
      req_mix_in_right <= w.in_right;
      req_start_frame <= w.start_frame;
      req_start_phase <= w.start_phase;
      do @(posedge clock); while (req_stall);
      advance_voice(w);
      words_sent++;
   endtask

   // A word with every field random; mix inputs sometimes at full scale.
   function automatic voice_word_type noise_word(logic [1:0] cmd);
      voice_word_type w;
      w.cmd = cmd;
      w.store_addr = 14'($urandom);
      w.store_word = 16'($urandom);
      w.in_left = 16'($urandom);
      w.in_right = 16'($urandom);
      w.start_frame = 14'($urandom);
      w.start_phase = 20'($urandom);
      if ($urandom_range(0, 7) == 0) w.in_left = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if ($urandom_range(0, 7) == 0) w.in_right = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      return w;
   endfunction

   function automatic voice_word_type mix_word(logic signed [15:0] l, logic signed [15:0] r);
      voice_word_type w;
      w = noise_word(rvm_pkg::CMD_MIX);
      w.in_left = l;
      w.in_right = r;
      return w;
   endfunction

   function automatic voice_word_type store_word(logic [13:0] a, logic [15:0] d);
      voice_word_type w;
      w = noise_word(rvm_pkg::CMD_WRITE);
      w.store_addr = a;
      w.store_word = d;
      return w;
   endfunction

   function automatic voice_word_type seek_word(logic [13:0] fr, logic [19:0] ph);
      voice_word_type w;
      w = noise_word(rvm_pkg::CMD_SEEK);
      w.start_frame = fr;
      w.start_phase = ph;
      return w;
   endfunction

   // A store entry that the coming mix reads and that holds no data yet is written first.
   task automatic fill_ahead(voice_word_type w);
      logic [15:0] fr;
      logic [13:0] addr_a;
      logic [13:0] addr_b;
      if (w.cmd == rvm_pkg::CMD_MIX) begin
         fr = play_frame;
         if (voice_cfg.looping && fr >= {1'b0, voice_cfg.frame_count}) begin
            fr = fr - {1'b0, voice_cfg.frame_count};
         end
         if (fr < {1'b0, voice_cfg.frame_count}) begin
            addr_a = voice_cfg.stereo_source ? {fr[12:0], 1'b0} : fr[13:0];
            addr_b = {fr[12:0], 1'b1};
            if (!store_written[addr_a]) begin
               drive_word(store_word(addr_a, 16'($urandom)));
            end
            if (voice_cfg.stereo_source && !store_written[addr_b]) begin
               drive_word(store_word(addr_b, 16'($urandom)));
            end
         end
      end
   endtask

   // Sends one word; a mix never reads a store entry that was not written.
   task automatic send_word(voice_word_type w);
      fill_ahead(w);
      drive_word(w);
   endtask

   // Waits until every expected frame is back and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(rvm_pkg::reg_idx_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         rvm_pkg::REG_SPEED_WHOLE: voice_cfg.speed_whole = value[13:0];
         rvm_pkg::REG_SPEED_PART: voice_cfg.speed_part = value[19:0];
         rvm_pkg::REG_RIGHT_GAIN: voice_cfg.right_gain = value[14:0];
         rvm_pkg::REG_LEFT_GAIN: voice_cfg.left_gain = value[14:0];
         rvm_pkg::REG_STEREO_SOURCE: voice_cfg.stereo_source = value[0];
         rvm_pkg::REG_EIGHT_BIT: voice_cfg.eight_bit = value[0];
         rvm_pkg::REG_LOOPING: voice_cfg.looping = value[0];
         rvm_pkg::REG_FRAME_COUNT: voice_cfg.frame_count = value[14:0];
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Full-scale samples pushed into full-scale stream values.
   task automatic test_saturation();
      send_word(store_word(14'd0, 16'h7FFF));
      send_word(store_word(14'd1, 16'h8000));
      send_word(seek_word(14'd0, 20'd0));
      send_word(mix_word(16'sh8000, 16'sh7FFF));
      send_word(mix_word(16'sh7FFF, 16'sh8000));
      send_word(noise_word(CMD_UNUSED));
      send_word(mix_word(16'sd0, 16'sd0));
   endtask

   // Last frame of the store wraps the stereo address; the voice then stops.
   task automatic test_store_wrap_and_end();
      send_word(seek_word(14'd16383, 20'hFFFFF));
      send_word(mix_word(16'sd1000, -16'sd1000));
      send_word(mix_word(16'sh7FFF, 16'sh8000));
      send_word(mix_word(16'sd5, -16'sd5));
   endtask

   // Mono 8-bit voice, clipped gain, phase carry and a loop wrap.
   task automatic test_eight_bit_mono_loop();
      settle();
      csr_write(rvm_pkg::REG_STEREO_SOURCE, 32'd0);
      csr_write(rvm_pkg::REG_EIGHT_BIT, 32'd1);
      csr_write(rvm_pkg::REG_RIGHT_GAIN, 32'd32767);
      csr_write(rvm_pkg::REG_LEFT_GAIN, 32'd0);
      csr_write(rvm_pkg::REG_LOOPING, 32'd1);
      csr_write(rvm_pkg::REG_FRAME_COUNT, 32'd7);
      csr_write(rvm_pkg::REG_SPEED_WHOLE, 32'd3);
      csr_write(rvm_pkg::REG_SPEED_PART, 32'h80000);
      send_word(store_word(14'd5, 16'h00FF));
      send_word(store_word(14'd2, 16'hFF00));
      send_word(seek_word(14'd5, 20'h80000));
      send_word(mix_word(16'sd0, 16'sd0));
      send_word(mix_word(16'sh8000, 16'sh7FFF));
      send_word(mix_word(16'sd100, -16'sd100));
   endtask

   // With no frames at all every mix reports the end, looping or not.
   task automatic test_zero_frames();
      settle();
      csr_write(rvm_pkg::REG_FRAME_COUNT, 32'd0);
      send_word(mix_word(16'sd7, -16'sd7));
      send_word(seek_word(14'd0, 20'd0));
      send_word(mix_word(16'sh7FFF, 16'sh8000));
   endtask

   // Random settings, each followed by a run of mostly mix words.
   task automatic test_random_voices();
      int run_len;
      int pick;
      int lim;
      rvm_pkg::cfg_type c;
      voice_word_type w;
      while (words_sent < WORD_TARGET) begin
         settle();
         idling_on = (words_sent < WORD_TARGET - CALM_WORDS) ? ($urandom_range(0, 3) != 0)
                                                              : 1'b0;
         case ($urandom_range(0, 5))
            0: c.speed_whole = 14'd0;
            1: c.speed_whole = 14'd1;
            2, 3: c.speed_whole = 14'($urandom_range(0, 3));
            4: c.speed_whole = 14'($urandom);
            default: c.speed_whole = 14'd16383;
         endcase
         case ($urandom_range(0, 3))
            0: c.speed_part = 20'd0;
            1: c.speed_part = 20'hFFFFF;
            default: c.speed_part = 20'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: c.right_gain = 15'd0;
            1: c.right_gain = 15'd16384;
            2: c.right_gain = 15'd32767;
            default: c.right_gain = 15'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: c.left_gain = 15'd0;
            1: c.left_gain = 15'd16384;
            2: c.left_gain = 15'd32767;
            default: c.left_gain = 15'($urandom);
         endcase
         c.stereo_source = 1'($urandom);
         c.eight_bit = 1'($urandom);
         c.looping = 1'($urandom);
         case ($urandom_range(0, 6))
            0: c.frame_count = 15'd0;
            1: c.frame_count = 15'd1;
            2, 3: c.frame_count = 15'($urandom_range(2, 64));
            4: c.frame_count = 15'($urandom_range(1, 16384));
            5: c.frame_count = 15'd16384;
            default: c.frame_count = 15'd32767;
         endcase
         csr_write(rvm_pkg::REG_SPEED_WHOLE, {18'd0, c.speed_whole});
         csr_write(rvm_pkg::REG_SPEED_PART, {12'd0, c.speed_part});
         csr_write(rvm_pkg::REG_RIGHT_GAIN, {17'd0, c.right_gain});
         csr_write(rvm_pkg::REG_LEFT_GAIN, {17'd0, c.left_gain});
         csr_write(rvm_pkg::REG_STEREO_SOURCE, {31'd0, c.stereo_source});
         csr_write(rvm_pkg::REG_EIGHT_BIT, {31'd0, c.eight_bit});
         csr_write(rvm_pkg::REG_LOOPING, {31'd0, c.looping});
         csr_write(rvm_pkg::REG_FRAME_COUNT, {17'd0, c.frame_count});
         run_len = $urandom_range(40, 150);
         for (int i = 0; i < run_len; i++) begin
            pick = (i == 0) ? 85 : $urandom_range(0, 99);
            if (pick < 68) begin
               w = noise_word(rvm_pkg::CMD_MIX);
            end else if (pick < 80) begin
               w = noise_word(rvm_pkg::CMD_WRITE);
            end else if (pick < 94) begin
               // Seeks mostly land inside the voice so that it plays for a while.
               w = noise_word(rvm_pkg::CMD_SEEK);
               if (voice_cfg.frame_count != 0 && $urandom_range(0, 3) != 0) begin
                  lim = (voice_cfg.frame_count > 15'd16384) ? 16383
                        : int'(voice_cfg.frame_count) - 1;
                  w.start_frame = 14'($urandom_range(0, lim));
               end
            end else begin
               w = noise_word(CMD_UNUSED);
            end
            send_word(w);
         end
      end
   endtask

   // Result side stalls in short random bursts while idling is on.
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each accepted result word is compared with the oldest expected frame.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual %0d %0d %0b",
                     $time, rsp_mix_out_left, rsp_mix_out_right, rsp_ended);
            errors++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_mix_out_left !== want.left) begin
               $display("%0t: mix_out_left expected %0d, actual %0d",
                        $time, want.left, rsp_mix_out_left);
               errors++;
            end
            if (rsp_mix_out_right !== want.right) begin
               $display("%0t: mix_out_right expected %0d, actual %0d",
                        $time, want.right, rsp_mix_out_right);
               errors++;
            end
            if (rsp_ended !== want.ended) begin
               $display("%0t: ended expected %0b, actual %0b", $time, want.ended, rsp_ended);
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d frames outstanding", $time, pending_frames.size());
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_saturation();
      test_store_wrap_and_end();
      test_eight_bit_mono_loop();
      test_zero_frames();
      test_random_voices();
      settle();
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
